>>> rtl/vdh_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup hash table package
// Shared constants, the queue entry type and the hash helpers.
// ----------------------------------------------------------------------------
package vdh_pkg;

    localparam int TABLE_DEPTH    = 65536;
    localparam int COORD_W        = 32;
    localparam int INDEX_W        = 16;
    localparam int CAP_LOG2_W     = 5;
    localparam int CAP_LOG2_LIMIT = 16;
    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RESET = 5'd16;
    localparam int EPOCH_W        = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MIX_STEPS      = 7;
    localparam int STEP_W         = $clog2(MIX_STEPS);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               start_mesh;
        logic [COORD_W-1:0] hash;
    } vdh_entry_t;

    function automatic logic [COORD_W-1:0] rotl32(input logic [COORD_W-1:0] v,
                                                  input int unsigned k);
        return (v << k) | (v >> (COORD_W - k));
    endfunction

    // One line of the final mix: t = (t ^ s) - rotl(s, k).
    function automatic logic [COORD_W-1:0] mix_line(input logic [COORD_W-1:0] t,
                                                    input logic [COORD_W-1:0] s,
                                                    input int unsigned k);
        return (t ^ s) - rotl32(s, k);
    endfunction

endpackage

>>> rtl/vertex_dedup_hash_table_top.sv
// ----------------------------------------------------------------------------
// Vertex dedup hash table
// Gives each distinct vertex a dense index through a linear-probing hash
// table, with a hashing front end and a probing back end joined by a queue.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                   | Beat
//  ---------+-----------------------------+-------------------------------------
//  input    | start high, busy low        | coord_x/y/z, start_mesh
//  result   | done high for one cycle     | vertex_index, is_new, table_full
//  config   | cfg_valid and cfg_ready     | cfg_data (capacity_log2)
//
// The front end takes one vertex at a time: it loads it, runs the final mix
// and hands it to the queue before it takes the next. The back end pops an
// entry, then per slot probed reads the slot, reads the store and compares;
// an empty slot ends probing. After reset busy stays high while the slot table
// is swept clear. Every 256th start_mesh repeats that sweep before the vertex.
// The result side cannot stall; the queue lets hashing run ahead of probing.
// ----------------------------------------------------------------------------
module vertex_dedup_hash_table_top #(
    parameter int TABLE_DEPTH = vdh_pkg::TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [vdh_pkg::COORD_W-1:0]    coord_x,
    input  logic [vdh_pkg::COORD_W-1:0]    coord_y,
    input  logic [vdh_pkg::COORD_W-1:0]    coord_z,
    input  logic                           start_mesh,
    output logic                           done,
    output logic [vdh_pkg::INDEX_W-1:0]    vertex_index,
    output logic                           is_new,
    output logic                           table_full,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vdh_pkg::CAP_LOG2_W-1:0] cfg_data
);

    logic [vdh_pkg::CAP_LOG2_W-1:0] capacity_log2_reg;
    logic                           front_busy;
    logic                           init_busy;
    logic                           push_valid;
    logic                           push_ready;
    vdh_pkg::vdh_entry_t            push_entry;
    logic                           pop_valid;
    logic                           pop;
    vdh_pkg::vdh_entry_t            pop_entry;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy || init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_log2_reg <= vdh_pkg::CAP_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_log2_reg <= cfg_data;
        end
    end

    vdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !busy),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .start_mesh (start_mesh),
        .front_busy (front_busy),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    vdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    vdh_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_log2 (capacity_log2_reg),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .init_busy     (init_busy),
        .done          (done),
        .vertex_index  (vertex_index),
        .is_new        (is_new),
        .table_full    (table_full)
    );

endmodule

>>> rtl/vdh_ram.sv
// ----------------------------------------------------------------------------
// Vertex dedup generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/vdh_front.sv
// ----------------------------------------------------------------------------
// Vertex dedup front end
// Takes a vertex, runs the 96-bit final mix one line per cycle and pushes
// the vertex with its hash into the queue.
// ----------------------------------------------------------------------------
module vdh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vdh_pkg::COORD_W-1:0] coord_x,
    input  logic [vdh_pkg::COORD_W-1:0] coord_y,
    input  logic [vdh_pkg::COORD_W-1:0] coord_z,
    input  logic                        start_mesh,
    output logic                        front_busy,
    output logic                        push_valid,
    output vdh_pkg::vdh_entry_t         push_entry,
    input  logic                        push_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIX  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [vdh_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [vdh_pkg::COORD_W-1:0]       a_reg, a_next;
    logic [vdh_pkg::COORD_W-1:0]       b_reg, b_next;
    logic [vdh_pkg::COORD_W-1:0]       c_reg, c_next;
    logic [vdh_pkg::COORD_W-1:0]       x_reg, x_next;
    logic [vdh_pkg::COORD_W-1:0]       y_reg, y_next;
    logic [vdh_pkg::COORD_W-1:0]       z_reg, z_next;
    logic                              mesh_reg, mesh_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        mesh_reg <= mesh_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        mesh_next  = mesh_reg;
        push_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = coord_x;
                    b_next     = coord_y;
                    c_next     = coord_z;
                    x_next     = coord_x;
                    y_next     = coord_y;
                    z_next     = coord_z;
                    mesh_next  = start_mesh;
                    step_next  = '0;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                case (step_reg)
                    3'd0:    c_next = vdh_pkg::mix_line(c_reg, b_reg, 14);
                    3'd1:    a_next = vdh_pkg::mix_line(a_reg, c_reg, 11);
                    3'd2:    b_next = vdh_pkg::mix_line(b_reg, a_reg, 25);
                    3'd3:    c_next = vdh_pkg::mix_line(c_reg, b_reg, 16);
                    3'd4:    a_next = vdh_pkg::mix_line(a_reg, c_reg, 4);
                    3'd5:    b_next = vdh_pkg::mix_line(b_reg, a_reg, 14);
                    default: c_next = vdh_pkg::mix_line(c_reg, b_reg, 24);
                endcase
                if (step_reg == vdh_pkg::STEP_W'(vdh_pkg::MIX_STEPS - 1))
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign front_busy            = (state_reg != S_IDLE);
    assign push_entry.x          = x_reg;
    assign push_entry.y          = y_reg;
    assign push_entry.z          = z_reg;
    assign push_entry.start_mesh = mesh_reg;
    assign push_entry.hash       = c_reg;

endmodule

>>> rtl/vdh_queue.sv
// ----------------------------------------------------------------------------
// Vertex dedup queue
// Short register FIFO between the hashing front end and the probing back end.
// ----------------------------------------------------------------------------
module vdh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  vdh_pkg::vdh_entry_t push_entry,
    output logic                push_ready,
    output logic                pop_valid,
    output vdh_pkg::vdh_entry_t pop_entry,
    input  logic                pop
);

    localparam int PTR_W = (vdh_pkg::QUEUE_DEPTH > 1) ? $clog2(vdh_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(vdh_pkg::QUEUE_DEPTH + 1);

    vdh_pkg::vdh_entry_t entries [vdh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(vdh_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(vdh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(vdh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/vdh_back.sv
// ----------------------------------------------------------------------------
// Vertex dedup back end
// Pops hashed vertices, probes the slot table linearly, compares against the
// vertex store and inserts new vertices. Owns the slot clearing sweep.
// ----------------------------------------------------------------------------
module vdh_back #(
    parameter int TABLE_DEPTH = vdh_pkg::TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [vdh_pkg::CAP_LOG2_W-1:0] capacity_log2,
    input  logic                           pop_valid,
    input  vdh_pkg::vdh_entry_t            pop_entry,
    output logic                           pop,
    output logic                           init_busy,
    output logic                           done,
    output logic [vdh_pkg::INDEX_W-1:0]    vertex_index,
    output logic                           is_new,
    output logic                           table_full
);

    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_LOG_MAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int EPOCH_W     = vdh_pkg::EPOCH_W;
    localparam int SLOT_W      = EPOCH_W + CNT_W;
    localparam int VTX_W       = 3 * vdh_pkg::COORD_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_VTX   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic                          init_reg, init_next;
    logic [ADDR_W-1:0]             clear_addr_reg, clear_addr_next;
    logic [EPOCH_W-1:0]            epoch_reg, epoch_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic [ADDR_W-1:0]             probe_reg, probe_next;
    logic [ADDR_W-1:0]             vi_reg, vi_next;
    logic [VTX_W-1:0]              vtx_reg, vtx_next;
    logic                          done_reg, done_next;
    logic [vdh_pkg::INDEX_W-1:0]   index_reg, index_next;
    logic                          new_reg, new_next;
    logic                          full_reg, full_next;

    logic [vdh_pkg::CAP_LOG2_W-1:0] cap_log;
    logic [ADDR_W-1:0]              mask;

    logic                slot_we, slot_re;
    logic [ADDR_W-1:0]   slot_waddr;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;
    logic                vtx_we, vtx_re;
    logic [ADDR_W-1:0]   vtx_waddr, vtx_raddr;
    logic [VTX_W-1:0]    vtx_rdata;
    logic [CNT_W-1:0]    slot_value;
    logic                slot_used;

    vdh_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (pos_reg),
        .rdata (slot_rdata)
    );

    vdh_ram #(
        .WIDTH (VTX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (vtx_waddr),
        .wdata (vtx_reg),
        .re    (vtx_re),
        .raddr (vtx_raddr),
        .rdata (vtx_rdata)
    );

    always_comb
    begin
        cap_log = capacity_log2;
        if (cap_log < 5'd1)
        begin
            cap_log = 5'd1;
        end
        if (cap_log > vdh_pkg::CAP_LOG2_W'(vdh_pkg::CAP_LOG2_LIMIT))
        begin
            cap_log = vdh_pkg::CAP_LOG2_W'(vdh_pkg::CAP_LOG2_LIMIT);
        end
        if (cap_log > vdh_pkg::CAP_LOG2_W'(CAP_LOG_MAX))
        begin
            cap_log = vdh_pkg::CAP_LOG2_W'(CAP_LOG_MAX);
        end
    end

    assign mask       = ~({ADDR_W{1'b1}} << cap_log);
    assign slot_value = slot_rdata[CNT_W-1:0];
    assign slot_used  = (slot_rdata[SLOT_W-1 -: EPOCH_W] == epoch_reg) && (slot_value != '0);
    assign vtx_raddr  = ADDR_W'(slot_value - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        clear_addr_next = clear_addr_reg;
        epoch_next      = epoch_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        vi_next         = vi_reg;
        vtx_next        = vtx_reg;
        done_next       = 1'b0;
        index_next      = index_reg;
        new_next        = new_reg;
        full_next       = full_reg;
        pop             = 1'b0;
        slot_we         = 1'b0;
        slot_re         = 1'b0;
        slot_waddr      = pos_reg;
        slot_wdata      = {epoch_reg, CNT_W'(count_reg + 1'b1)};
        vtx_we          = 1'b0;
        vtx_re          = 1'b0;
        vtx_waddr       = ADDR_W'(count_reg);
        case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clear_addr_reg;
                slot_wdata = '0;
                if (clear_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    epoch_next      = '0;
                    init_next       = 1'b0;
                    clear_addr_next = '0;
                    state_next      = init_reg ? S_IDLE : S_PROBE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    pop        = 1'b1;
                    vtx_next   = {pop_entry.z, pop_entry.y, pop_entry.x};
                    pos_next   = pop_entry.hash[ADDR_W-1:0] & mask;
                    probe_next = '0;
                    state_next = S_PROBE;
                    if (pop_entry.start_mesh)
                    begin
                        count_next = '0;
                        if (epoch_reg == {EPOCH_W{1'b1}})
                        begin
                            clear_addr_next = '0;
                            state_next      = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                slot_re    = 1'b1;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                if (!slot_used)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        index_next = '0;
                        new_next   = 1'b0;
                        full_next  = 1'b1;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        vtx_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        index_next = vdh_pkg::INDEX_W'(count_reg);
                        new_next   = 1'b1;
                        full_next  = 1'b0;
                    end
                end
                else
                begin
                    vtx_re     = 1'b1;
                    vi_next    = vtx_raddr;
                    state_next = S_VTX;
                end
            end
            S_VTX:
            begin
                if (vtx_rdata == vtx_reg)
                begin
                    done_next  = 1'b1;
                    index_next = vdh_pkg::INDEX_W'(vi_reg);
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (probe_reg == mask)
                begin
                    done_next  = 1'b1;
                    index_next = '0;
                    new_next   = 1'b0;
                    full_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    pos_next   = (pos_reg + 1'b1) & mask;
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            init_reg       <= 1'b1;
            clear_addr_reg <= '0;
            epoch_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            clear_addr_reg <= clear_addr_next;
            epoch_reg      <= epoch_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        probe_reg <= probe_next;
        vi_reg    <= vi_next;
        vtx_reg   <= vtx_next;
        index_reg <= index_next;
        new_reg   <= new_next;
        full_reg  <= full_next;
    end

    assign init_busy    = init_reg;
    assign done         = done_reg;
    assign vertex_index = index_reg;
    assign is_new       = new_reg;
    assign table_full   = full_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex dedup hash table testbench
// Sends vertices through the start/busy command port and checks every strobed
// result against a linear-probing predictor kept alongside the block. The run
// starts with short directed runs for the word extremes, repeats, table full
// and capacity changes within a mesh. It then goes through random phases at
// several capacities and sender idle rates. Most random vertices repeat or
// nearly repeat one already seen in the current mesh.
// ----------------------------------------------------------------------------

import vdh_pkg::*;

class weld_predictor;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic               is_new;
        logic               full;
    } weld_result_t;

    weld_result_t           pending_results[$];
    int unsigned            slot_map[int unsigned];
    logic [3*COORD_W-1:0]   vertex_words[int unsigned];
    int unsigned            stored;
    logic [CAP_LOG2_W-1:0]  cap_log2;
    int                     errors;

    function new();
        cap_log2 = CAP_LOG2_RESET;
        stored   = 0;
        errors   = 0;
    endfunction

    task report_error(input string msg);
        errors++;
        if (errors <= 100)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function int pending();
        return pending_results.size();
    endfunction

    function void note_capacity(input logic [CAP_LOG2_W-1:0] value);
        cap_log2 = value;
    endfunction

    function logic [COORD_W-1:0] rot_left(input logic [COORD_W-1:0] v, input int k);
        return (v << k) | (v >> (COORD_W - k));
    endfunction

    function logic [COORD_W-1:0] final_mix(input logic [COORD_W-1:0] a,
                                           input logic [COORD_W-1:0] b,
                                           input logic [COORD_W-1:0] c);
        c = (c ^ b) - rot_left(b, 14);
        a = (a ^ c) - rot_left(c, 11);
        b = (b ^ a) - rot_left(a, 25);
        c = (c ^ b) - rot_left(b, 16);
        a = (a ^ c) - rot_left(c, 4);
        b = (b ^ a) - rot_left(a, 14);
        c = (c ^ b) - rot_left(b, 24);
        return c;
    endfunction

    function int unsigned slots_in_use();
        int unsigned lg;
        int unsigned span;
        lg = cap_log2;
        if (lg < 1)
        begin
            lg = 1;
        end
        if (lg > CAP_LOG2_LIMIT)
        begin
            lg = CAP_LOG2_LIMIT;
        end
        span = 1 << lg;
        while (span > TABLE_DEPTH && span > 1)
        begin
            span = span >> 1;
        end
        return span;
    endfunction

    function void note_vertex(input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z,
                              input logic new_mesh);
        weld_result_t         r;
        logic [3*COORD_W-1:0] key;
        int unsigned          span;
        int unsigned          hash;
        int unsigned          pos;
        int unsigned          vi;
        int unsigned          i;
        key = {x, y, z};
        if (new_mesh)
        begin
            slot_map.delete();
            stored = 0;
        end
        span     = slots_in_use();
        hash     = final_mix(x, y, z);
        r.index  = '0;
        r.is_new = 1'b0;
        r.full   = 1'b1;
        for (i = 0; i < span; i++)
        begin
            pos = (hash + i) & (span - 1);
            if (!slot_map.exists(pos))
            begin
                if (stored < TABLE_DEPTH)
                begin
                    vertex_words[stored] = key;
                    slot_map[pos]        = stored + 1;
                    r.index              = stored[INDEX_W-1:0];
                    r.is_new             = 1'b1;
                    r.full               = 1'b0;
                    stored++;
                end
                break;
            end
            vi = slot_map[pos] - 1;
            if (vertex_words[vi] == key)
            begin
                r.index = vi[INDEX_W-1:0];
                r.full  = 1'b0;
                break;
            end
        end
        pending_results.push_back(r);
    endfunction

    task check_result(input logic [INDEX_W-1:0] index,
                      input logic is_new,
                      input logic full);
        weld_result_t e;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("result with nothing pending, index %0d", index));
            return;
        end
        e = pending_results.pop_front();
        if (index !== e.index)
        begin
            report_error($sformatf("vertex_index %0d, expected %0d", index, e.index));
        end
        if (is_new !== e.is_new)
        begin
            report_error($sformatf("is_new %b, expected %b", is_new, e.is_new));
        end
        if (full !== e.full)
        begin
            report_error($sformatf("table_full %b, expected %b", full, e.full));
        end
    endtask

endclass

module tb;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic [COORD_W-1:0]    coord_x    = '0;
    logic [COORD_W-1:0]    coord_y    = '0;
    logic [COORD_W-1:0]    coord_z    = '0;
    logic                  start_mesh = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CAP_LOG2_W-1:0] cfg_data   = '0;
    logic                  busy;
    logic                  done;
    logic [INDEX_W-1:0]    vertex_index;
    logic                  is_new;
    logic                  table_full;
    logic                  cfg_ready;

    weld_predictor         weld_model = new();
    logic [3*COORD_W-1:0]  mesh_pool[$];

    vertex_dedup_hash_table_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .start_mesh   (start_mesh),
        .done         (done),
        .vertex_index (vertex_index),
        .is_new       (is_new),
        .table_full   (table_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                weld_model.check_result(vertex_index, is_new, table_full);
            end
            if (cfg_valid && cfg_ready)
            begin
                weld_model.note_capacity(cfg_data);
            end
            if (start && !busy)
            begin
                weld_model.note_vertex(coord_x, coord_y, coord_z, start_mesh);
            end
        end
    end

    task automatic send_vertex(input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z,
                               input logic new_mesh);
        start      <= 1'b1;
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        start_mesh <= new_mesh;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
    endtask

    task automatic sender_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct)
        begin
            n++;
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (weld_model.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_LOG2_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_vertex(input int mesh_pct);
        logic [3*COORD_W-1:0] v;
        logic                 new_mesh;
        int                   pick;
        new_mesh = ($urandom_range(99) < mesh_pct);
        pick     = $urandom_range(99);
        v        = {$urandom, $urandom, $urandom};
        if (mesh_pool.size() != 0 && pick < 60)
        begin
            v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
            if (pick >= 50)
            begin
                v[$urandom_range(3*COORD_W - 1)] ^= 1'b1;
            end
            else if (pick >= 40)
            begin
                case ($urandom_range(2))
                    0: v[3*COORD_W-1:2*COORD_W] = $urandom;
                    1: v[2*COORD_W-1:COORD_W]   = $urandom;
                    default: v[COORD_W-1:0]     = $urandom;
                endcase
            end
        end
        if (new_mesh)
        begin
            mesh_pool.delete();
        end
        mesh_pool.push_back(v);
        send_vertex(v[3*COORD_W-1:2*COORD_W], v[2*COORD_W-1:COORD_W], v[COORD_W-1:0],
                    new_mesh);
    endtask

    initial
    begin
        logic [CAP_LOG2_W-1:0] phase_cap[6];
        int                    phase_idle[6];
        int                    phase_items[6];
        int                    phase_mesh[6];
        logic [COORD_W-1:0]    ax;
        logic [COORD_W-1:0]    bx;
        logic [COORD_W-1:0]    cx;
        int                    p;
        int                    n;

        phase_cap   = '{5'd16, 5'd3, 5'd10, 5'd17, 5'd2, 5'd6};
        phase_idle  = '{0, 87, 0, 19, 87, 0};
        phase_items = '{500, 300, 400, 400, 150, 150};
        phase_mesh  = '{1, 4, 2, 1, 5, 3};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_vertex('0, '0, '0, 1'b1);
        send_vertex('0, '0, '0, 1'b0);
        send_vertex('1, '1, '1, 1'b0);
        send_vertex('1, '0, '0, 1'b0);
        send_vertex('0, '1, '0, 1'b0);
        send_vertex('0, '0, '1, 1'b0);
        send_vertex('1, '1, '1, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);

        // Shrink the capacity in the middle of a mesh.
        drain();
        write_capacity(5'd1);
        send_vertex('1, '1, '1, 1'b0);
        send_vertex('0, '0, '0, 1'b0);
        send_vertex($urandom, $urandom, $urandom, 1'b0);
        send_vertex($urandom, $urandom, $urandom, 1'b0);

        // A capacity of zero probes two slots, so the third vertex finds the table full.
        drain();
        write_capacity(5'd0);
        ax = $urandom;
        bx = ax ^ 32'h0000_0100;
        cx = ax ^ 32'h0001_0000;
        send_vertex(ax, 32'h1234_5678, '0, 1'b1);
        send_vertex(bx, 32'h1234_5678, '0, 1'b0);
        send_vertex(cx, 32'h1234_5678, '0, 1'b0);
        send_vertex(ax, 32'h1234_5678, '0, 1'b0);
        send_vertex(cx, 32'h1234_5678, '0, 1'b0);
        send_vertex(cx, 32'h1234_5678, '0, 1'b1);

        drain();
        write_capacity(5'd31);
        send_vertex(bx, cx, ax, 1'b1);
        send_vertex(bx, cx, ax, 1'b0);
        send_vertex('0, '0, '0, 1'b0);

        for (p = 0; p < 6; p++)
        begin
            drain();
            write_capacity(phase_cap[p]);
            for (n = 0; n < phase_items[p]; n++)
            begin
                send_random_vertex(phase_mesh[p]);
                sender_gap(phase_idle[p]);
                if (p == 3 && $urandom_range(99) < 2)
                begin
                    drain();
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (weld_model.errors == 0 && weld_model.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/vdh_pkg.sv
rtl/vdh_ram.sv
rtl/vdh_front.sv
rtl/vdh_queue.sv
rtl/vdh_back.sv
rtl/vertex_dedup_hash_table_top.sv
sim/tb.sv
